[design/joint_homing_slew_limiter_defines.svh]
// assertion macros for the joint homing slew limiter checker
// the enclosing scope must provide clk and arst_n
`ifndef JOINT_HOMING_SLEW_LIMITER_DEFINES_SVH
`define JOINT_HOMING_SLEW_LIMITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define JHSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define JHSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/jhsl_pkg.sv]
// shared types, codes and defaults of the joint homing slew limiter
// no dependencies
`default_nettype none

package jhsl_pkg;

	localparam int JOINTS_DEF    = 32;
	localparam int POS_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	// wide enough for any difference or sum of positions up to 32 bits
	localparam int CALC_W        = 34;

	localparam int CFG_W       = 15;
	localparam int JC_W        = 6;
	localparam int MAX_OUT     = 32;

	localparam logic [CFG_W-1:0] MAX_STEP_RST  = 15'd0;
	localparam logic [CFG_W-1:0] PRECISION_RST = 15'd82;  // 0.02 rad in q3.12
	localparam logic [JC_W-1:0]  JC_RST        = 6'd32;

	typedef enum logic [1:0] {
		REG_MAX_STEP  = 2'd0,
		REG_PRECISION = 2'd1,
		REG_JOINT_CNT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_WR_TARGET = 2'd0,
		OP_LD_POS    = 2'd1,
		OP_HOME      = 2'd2,
		OP_TICK      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_READY  = 2'd0,
		MODE_MOVING = 2'd1,
		MODE_HOME   = 2'd2
	} mode_t;

	localparam logic KIND_CMD    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] max_step;
		logic [CFG_W-1:0] precision;
		logic [JC_W-1:0]  joint_count;
	} cfg_t;

	// classified item as it travels through the queue
	typedef struct packed {
		logic               wr_tgt;
		logic               wr_pos;
		logic               start;
		logic               tick;
		logic [4:0]         joint;
		logic signed [15:0] value;
	} fe_item_t;

endpackage

`default_nettype wire

[design/joint_homing_slew_limiter.sv]
// joint homing slew limiter, top level: config registers, front end, queue, back end
// depends on jhsl_pkg, jhsl_front, jhsl_fifo, jhsl_back
//
// channel   direction  handshake             payload
// in        to block   in_valid / in_stall   opcode, joint, value
// out       from block out_valid / out_stall kind, joint_index, position, mode, last
// cfg       to block   cfg_we                cfg_index, cfg_data
//
// writes, loads and start homing pass the front register and the queue to the idle back end
// a tick while moving checks joints until one is off goal (one joint per cycle, one ram read
// port per table); if one is off goal, it steps every joint in use, one per cycle unless stalled
// reset is asynchronous; targets read as zero until written, positions are undefined until loaded
// a stalled output holds the step sequencer; the front keeps accepting until the queue fills
`default_nettype none

module joint_homing_slew_limiter #(
	parameter int JOINTS    = jhsl_pkg::JOINTS_DEF,
	parameter int POS_WIDTH = jhsl_pkg::POS_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 opcode,
	input  wire logic [4:0]                 joint,
	input  wire logic signed [15:0]         value,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            kind,
	output logic [4:0]                      joint_index,
	output logic signed [15:0]              position,
	output logic [1:0]                      mode,
	output logic                            last,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [jhsl_pkg::CFG_W-1:0] cfg_data
);
	import jhsl_pkg::*;

	cfg_t     cfg_q;
	logic     push;
	fe_item_t push_item;
	logic     q_full;
	logic     q_not_empty;
	logic     pop;
	fe_item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_step    <= MAX_STEP_RST;
			cfg_q.precision   <= PRECISION_RST;
			cfg_q.joint_count <= JC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_STEP:  cfg_q.max_step    <= cfg_data;
				REG_PRECISION: cfg_q.precision   <= cfg_data;
				REG_JOINT_CNT: cfg_q.joint_count <= cfg_data[JC_W-1:0];
				default:       cfg_q             <= cfg_q;
			endcase
		end
	end

	jhsl_front #(.JOINTS(JOINTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.joint     (joint),
		.value     (value),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	jhsl_fifo #(.WIDTH($bits(fe_item_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_item),
		.full      (q_full),
		.pop       (pop),
		.rdata     (q_item),
		.not_empty (q_not_empty)
	);

	jhsl_back #(.JOINTS(JOINTS), .POS_WIDTH(POS_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (q_not_empty),
		.item        (q_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.joint_index (joint_index),
		.position    (position),
		.mode        (mode),
		.last        (last)
	);

endmodule

`default_nettype wire

[design/jhsl_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module jhsl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                    wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/jhsl_front.sv]
// front end: takes input transfers, decodes the opcode, checks the joint range
// depends on jhsl_pkg
`default_nettype none

module jhsl_front #(
	parameter int JOINTS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          opcode,
	input  wire logic [4:0]          joint,
	input  wire logic signed [15:0]  value,
	output logic                     push,
	output jhsl_pkg::fe_item_t       push_item,
	input  wire logic                q_full
);
	import jhsl_pkg::*;

	logic     fe_v_s1;
	fe_item_t fe_item_s1;
	fe_item_t dec;
	logic     in_range;
	logic     accept;

	assign in_range = (32'(joint) < JOINTS);

	always_comb begin
		dec        = '0;
		dec.joint  = joint;
		dec.value  = value;
		unique case (opcode)
			OP_WR_TARGET: dec.wr_tgt = in_range;
			OP_LD_POS:    dec.wr_pos = in_range;
			OP_HOME:      dec.start  = 1'b1;
			OP_TICK:      dec.tick   = 1'b1;
			default:      dec        = '0;
		endcase
	end

	assign in_stall  = fe_v_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = fe_v_s1 && !q_full;
	assign push_item = fe_item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				fe_v_s1    <= 1'b1;
				fe_item_s1 <= dec;
			end else if (push) begin
				fe_v_s1 <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[design/jhsl_fifo.sv]
// short queue between front and back end
// depends on nothing but its parameters
`default_nettype none

module jhsl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				mem_q[wr_ptr_q] <= wdata;
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/jhsl_back.sv]
// back end: table writes, goal check and slew-limited step, result register
// depends on jhsl_pkg and jhsl_ram
`default_nettype none

module jhsl_back #(
	parameter int JOINTS    = 32,
	parameter int POS_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire jhsl_pkg::cfg_t      cfg,
	input  wire logic                item_valid,
	input  wire jhsl_pkg::fe_item_t  item,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     kind,
	output logic [4:0]               joint_index,
	output logic signed [15:0]       position,
	output logic [1:0]               mode,
	output logic                     last
);
	import jhsl_pkg::*;

	localparam int IW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int LIM = (JOINTS < MAX_OUT) ? JOINTS : MAX_OUT;
	localparam logic signed [CALC_W-1:0] POS_HI =
		CALC_W'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
	localparam logic signed [CALC_W-1:0] POS_LO = -POS_HI - 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STEP
	} state_t;

	state_t                       state_q;
	mode_t                        mode_q;
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                idx_d;
	logic [JOINTS-1:0]            tgt_valid_q;

	logic                         out_valid_q;
	logic                         kind_q;
	logic [4:0]                   joint_index_q;
	logic signed [15:0]           position_q;
	logic [1:0]                   mode_out_q;
	logic                         last_q;

	logic                         out_free;
	logic                         out_load;
	logic                         tgt_we;
	logic                         pos_we;
	logic [IW-1:0]                item_addr;
	logic [IW-1:0]                pos_waddr;
	logic signed [POS_WIDTH-1:0]  pos_wdata;
	logic signed [POS_WIDTH-1:0]  tgt_rd;
	logic signed [POS_WIDTH-1:0]  pos_rd;
	logic signed [POS_WIDTH-1:0]  tgt_eff;
	logic signed [POS_WIDTH-1:0]  val_sat;
	logic signed [POS_WIDTH-1:0]  new_pos;

	logic signed [CALC_W-1:0]     val_w;
	logic signed [CALC_W-1:0]     tgt_w;
	logic signed [CALC_W-1:0]     pos_w;
	logic signed [CALC_W-1:0]     dist_w;
	logic signed [CALC_W-1:0]     abs_w;
	logic signed [CALC_W-1:0]     prec_w;
	logic signed [CALC_W-1:0]     lim_w;
	logic signed [CALC_W-1:0]     delta_w;
	logic signed [CALC_W-1:0]     dcl_w;
	logic signed [CALC_W-1:0]     sum_w;
	logic signed [CALC_W-1:0]     new_w;
	logic                         at_goal;
	logic                         at_last;
	logic [JC_W-1:0]              n_use;
	logic [IW-1:0]                last_idx;

	// joints in use: zero acts as one, clamp to the table size or MAX_OUT, whichever is less
	always_comb begin
		if (cfg.joint_count == '0) begin
			n_use = JC_W'(1);
		end else if (cfg.joint_count > JC_W'(LIM)) begin
			n_use = JC_W'(LIM);
		end else begin
			n_use = cfg.joint_count;
		end
	end
	assign last_idx = IW'(n_use - JC_W'(1));
	assign at_last  = (idx_q == last_idx);

	// input value saturated into the stored width
	assign val_w   = CALC_W'(signed'(item.value));
	assign val_sat = (val_w > POS_HI) ? POS_WIDTH'(POS_HI) :
	                 (val_w < POS_LO) ? POS_WIDTH'(POS_LO) : POS_WIDTH'(val_w);

	// never-written targets read as zero
	assign tgt_eff = tgt_valid_q[idx_q] ? tgt_rd : '0;
	assign tgt_w   = CALC_W'(tgt_eff);
	assign pos_w   = CALC_W'(pos_rd);

	assign dist_w  = pos_w - tgt_w;
	assign abs_w   = (dist_w < 0) ? -dist_w : dist_w;
	assign prec_w  = {{(CALC_W - CFG_W){1'b0}}, cfg.precision};
	assign at_goal = (abs_w <= prec_w);

	assign lim_w   = {{(CALC_W - CFG_W){1'b0}}, cfg.max_step};
	assign delta_w = tgt_w - pos_w;
	assign dcl_w   = (delta_w > lim_w) ? lim_w : (delta_w < -lim_w) ? -lim_w : delta_w;
	assign sum_w   = pos_w + dcl_w;
	assign new_pos = (sum_w > POS_HI) ? POS_WIDTH'(POS_HI) :
	                 (sum_w < POS_LO) ? POS_WIDTH'(POS_LO) : POS_WIDTH'(sum_w);
	assign new_w   = CALC_W'(new_pos);

	assign out_free  = !out_valid_q || !out_stall;
	assign item_addr = IW'(item.joint);

	always_comb begin
		pop       = 1'b0;
		tgt_we    = 1'b0;
		pos_we    = 1'b0;
		out_load  = 1'b0;
		pos_waddr = item_addr;
		pos_wdata = val_sat;
		idx_d     = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				idx_d  = '0;
				pop    = item_valid;
				tgt_we = item_valid && item.wr_tgt;
				pos_we = item_valid && item.wr_pos;
			end
			ST_CHECK: begin
				out_load = at_goal && at_last && out_free;
				// the ram reads idx_d, so its data next cycle belongs to idx_q
				if (!at_goal) begin
					idx_d = '0;
				end else if (!at_last) begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_STEP: begin
				if (out_free) begin
					out_load  = 1'b1;
					pos_we    = 1'b1;
					pos_waddr = idx_q;
					pos_wdata = new_pos;
					idx_d     = at_last ? '0 : idx_q + 1'b1;
				end
			end
			default: idx_d = '0;
		endcase
	end

	jhsl_ram #(.WIDTH(POS_WIDTH), .DEPTH(JOINTS)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (item_addr),
		.wdata (val_sat),
		.raddr (idx_d),
		.rdata (tgt_rd)
	);

	jhsl_ram #(.WIDTH(POS_WIDTH), .DEPTH(JOINTS)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (idx_d),
		.rdata (pos_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_READY;
			idx_q       <= '0;
			tgt_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tgt_we) begin
						tgt_valid_q[item_addr] <= 1'b1;
					end
					if (item_valid && item.start) begin
						mode_q <= MODE_MOVING;
					end
					if (item_valid && item.tick && mode_q == MODE_MOVING) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!at_goal) begin
						state_q <= ST_STEP;
					end else if (at_last && out_free) begin
						mode_q        <= MODE_HOME;
						kind_q        <= KIND_STATUS;
						joint_index_q <= '0;
						position_q    <= '0;
						mode_out_q    <= MODE_HOME;
						last_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				ST_STEP: begin
					if (out_free) begin
						kind_q        <= KIND_CMD;
						joint_index_q <= 5'(idx_q);
						position_q    <= new_w[15:0];
						mode_out_q    <= MODE_MOVING;
						last_q        <= at_last;
						if (at_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign joint_index = joint_index_q;
	assign position    = position_q;
	assign mode        = mode_out_q;
	assign last        = last_q;

endmodule

`default_nettype wire

[design/jhsl_checker.sv]
// port-level checker for the joint homing slew limiter, bound to the top level
// depends on jhsl_pkg and joint_homing_slew_limiter_defines.svh
`default_nettype none
`include "joint_homing_slew_limiter_defines.svh"

module jhsl_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               kind,
	input wire logic [4:0]         joint_index,
	input wire logic signed [15:0] position,
	input wire logic [1:0]         mode,
	input wire logic               last
);
	import jhsl_pkg::*;

	// a result held back keeps its place
	`JHSL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
	`JHSL_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(position) && $stable(joint_index) && $stable(kind) && $stable(last), "result changed under stall")
	// status report is the lone result of a tick that finds every joint at goal
	`JHSL_ASSERT_NOW(a_status_form, out_valid && kind == KIND_STATUS, mode == MODE_HOME && last && joint_index == 5'd0 && position == 16'sd0, "malformed status report")
	// position commands only come out of the moving mode
	`JHSL_ASSERT_NOW(a_cmd_mode, out_valid && kind == KIND_CMD, mode == MODE_MOVING, "command outside moving mode")

endmodule

bind joint_homing_slew_limiter jhsl_checker u_jhsl_checker (.*);

`default_nettype wire
